/* hdl/assert_macros.svh */
// assertion helpers included by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define DHTI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen at a clock edge outside reset
`define DHTI_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

/* hdl/dhti_pkg.sv */
package dhti_pkg;

    // payload field widths
    localparam int OP_W        = 2;
    localparam int KEY_FIELD_W = 31;
    localparam int SLOT_W      = 10;
    localparam int STATUS_W    = 2;
    localparam int PROBE_W     = 11;
    localparam int TSIZE_W     = 11;

    // default geometry
    localparam int DHTI_DEPTH     = 1024;
    localparam int DHTI_KEY_WIDTH = 31;

    // table size register
    localparam logic [TSIZE_W-1:0] TSIZE_RESET = 11'd1021;
    localparam int                 MIN_SIZE    = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_READ     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 2'd3;

endpackage

/* hdl/dhti_if.sv */
// request channel
interface dhti_req_if;
    import dhti_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        operation;
    logic [KEY_FIELD_W-1:0] key;
    logic [SLOT_W-1:0]      slot;

    modport source (output valid, output operation, output key, output slot, input ready);
    modport sink   (input valid, input operation, input key, input slot, output ready);
endinterface

// response channel
interface dhti_rsp_if;
    import dhti_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [SLOT_W-1:0]      slot_index;
    logic [KEY_FIELD_W-1:0] key_out;
    logic                   slot_used;
    logic [PROBE_W-1:0]     probe_count;

    modport source (output valid, output status, output slot_index, output key_out,
                    output slot_used, output probe_count, input ready);
    modport sink   (input valid, input status, input slot_index, input key_out,
                    input slot_used, input probe_count, output ready);
endinterface

// configuration write channel
interface dhti_cfg_if;
    import dhti_pkg::*;

    logic               valid;
    logic               ready;
    logic [TSIZE_W-1:0] table_size;

    modport source (output valid, output table_size, input ready);
    modport sink   (input valid, input table_size, output ready);
endinterface

/* hdl/dhti_mod.sv */
module dhti_mod #(
    parameter int DVD_W = 31,
    parameter int DVS_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVS_W-1:0] rem
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVS_W:0]   trial;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    // one restoring remainder step per cycle, msb first
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = DVS_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[DVS_W-1:0];
        end
    end

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(DVD_W);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* hdl/dhti_mem.sv */
module dhti_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/double_hash_table_insert_top.sv */
// Double-hashing open-addressed key table. An insert finds home = key mod S and
// step = 1 + key mod (S-1), S being table_size held to 2..DEPTH, then walks the
// slot memory one probe per cycle until an empty slot takes the key or the walk
// has seen S used slots. During an insert two bit-serial remainder units run side
// by side, then the single-port slot memory is read once per probe. A clear
// writes every slot's used flag through the one memory port. After reset the
// same pass runs over every slot before the first request is taken;
// configuration writes are taken at any time.
module double_hash_table_insert_top #(
    parameter int DEPTH     = dhti_pkg::DHTI_DEPTH,
    parameter int KEY_WIDTH = dhti_pkg::DHTI_KEY_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    dhti_req_if.sink   req,
    dhti_rsp_if.source rsp,
    dhti_cfg_if.sink   cfg
);
    import dhti_pkg::*;

`include "assert_macros.svh"

    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int SIZE_W   = ADDR_W + 1;
    localparam int KEY_BITS = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;
    localparam int MEM_W    = KEY_BITS + 1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_DIV,
        ST_PROBE,
        ST_READ,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [TSIZE_W-1:0]   tsize_reg;
    logic [SIZE_W-1:0]    eff_size;
    logic [SIZE_W-1:0]    eff_size_m1;
    logic [SIZE_W-1:0]    filled_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [KEY_BITS-1:0]  req_key;
    logic [ADDR_W-1:0]    step_reg;
    logic [ADDR_W-1:0]    issue_pos_reg;
    logic [SIZE_W-1:0]    issue_cnt_reg;
    logic [SIZE_W-1:0]    next_sum;
    logic [ADDR_W-1:0]    next_pos;
    logic [ADDR_W-1:0]    chk_pos_reg;
    logic [SIZE_W-1:0]    chk_cnt_reg;
    logic                 chk_vld_reg;
    logic                 rd_valid;
    logic                 found;
    logic                 walk_fail;
    logic                 issue;
    logic                 req_fire;
    logic                 slot_in_range;

    logic [STATUS_W-1:0]  res_status_reg;
    logic [SLOT_W-1:0]    res_slot_reg;
    logic [KEY_BITS-1:0]  res_key_reg;
    logic                 res_used_reg;
    logic [SIZE_W-1:0]    res_probe_reg;

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [KEY_FIELD_W-1:0] out_key_reg;
    logic                 out_used_reg;
    logic [PROBE_W-1:0]   out_probe_reg;

    logic                 mem_en;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_addr;
    logic [MEM_W-1:0]     mem_wdata;
    logic [MEM_W-1:0]     mem_rdata;

    logic                 div_start;
    logic                 div_a_done;
    logic                 div_b_done;
    logic [SIZE_W-1:0]    home_rem;
    logic [SIZE_W-1:0]    step_rem;

    // effective size, table_size held to 2..DEPTH
    always_comb
    begin
        if (tsize_reg < TSIZE_W'(MIN_SIZE))
        begin
            eff_size = SIZE_W'(MIN_SIZE);
        end
        else if (32'(tsize_reg) > DEPTH)
        begin
            eff_size = SIZE_W'(DEPTH);
        end
        else
        begin
            eff_size = SIZE_W'(tsize_reg);
        end
    end

    assign eff_size_m1 = eff_size - SIZE_W'(1);

    // table size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsize_reg <= TSIZE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            tsize_reg <= cfg.table_size;
        end
    end

    assign cfg.ready = 1'b1;

    // request decode
    assign req.ready     = (state_reg == ST_IDLE);
    assign req_fire      = req.valid && req.ready;
    assign req_key       = KEY_BITS'(req.key);
    assign slot_in_range = (32'(req.slot) < DEPTH);
    assign div_start     = req_fire && (req.operation == OP_INSERT) && (filled_reg < eff_size);

    // remainder units for home slot and step
    dhti_mod #(
        .DVD_W (KEY_BITS),
        .DVS_W (SIZE_W)
    ) u_mod_home (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req_key),
        .divisor  (eff_size),
        .done     (div_a_done),
        .rem      (home_rem)
    );

    dhti_mod #(
        .DVD_W (KEY_BITS),
        .DVS_W (SIZE_W)
    ) u_mod_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req_key),
        .divisor  (eff_size_m1),
        .done     (div_b_done),
        .rem      (step_rem)
    );

    // probe walk decisions
    assign rd_valid  = mem_rdata[KEY_BITS];
    assign found     = chk_vld_reg && !rd_valid;
    assign walk_fail = chk_vld_reg && rd_valid && (chk_cnt_reg == eff_size_m1);
    assign issue     = !found && !walk_fail && (issue_cnt_reg < eff_size);
    assign next_sum  = {1'b0, issue_pos_reg} + {1'b0, step_reg};
    assign next_pos  = (next_sum >= eff_size) ? ADDR_W'(next_sum - eff_size)
                                              : next_sum[ADDR_W-1:0];

    // slot memory port
    always_comb
    begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = issue_pos_reg;
        mem_wdata = {1'b1, key_reg};
        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = clr_addr_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                if (req_fire && (req.operation == OP_READ) && slot_in_range)
                begin
                    mem_en   = 1'b1;
                    mem_addr = ADDR_W'(req.slot);
                end
            end
            ST_PROBE:
            begin
                if (found)
                begin
                    mem_en   = 1'b1;
                    mem_we   = 1'b1;
                    mem_addr = chk_pos_reg;
                end
                else if (issue)
                begin
                    mem_en = 1'b1;
                end
            end
            default:
            begin
                mem_en = 1'b0;
            end
        endcase
    end

    dhti_mem #(
        .DEPTH (DEPTH),
        .WIDTH (MEM_W)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // control state machine and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            filled_reg     <= '0;
            clr_addr_reg   <= '0;
            key_reg        <= '0;
            step_reg       <= '0;
            issue_pos_reg  <= '0;
            issue_cnt_reg  <= '0;
            chk_pos_reg    <= '0;
            chk_cnt_reg    <= '0;
            chk_vld_reg    <= 1'b0;
            res_status_reg <= STATUS_INSERTED;
            res_slot_reg   <= '0;
            res_key_reg    <= '0;
            res_used_reg   <= 1'b0;
            res_probe_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_INSERTED;
            out_slot_reg   <= '0;
            out_key_reg    <= '0;
            out_used_reg   <= 1'b0;
            out_probe_reg  <= '0;
        end
        else
        begin
            // response transaction completes, unless a new result is loaded
            if (out_valid_reg && rsp.ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_INIT:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        res_key_reg   <= '0;
                        res_used_reg  <= 1'b0;
                        res_probe_reg <= '0;
                        res_slot_reg  <= '0;
                        priority if (req.operation == OP_INSERT)
                        begin
                            key_reg <= req_key;
                            if (filled_reg >= eff_size)
                            begin
                                res_status_reg <= STATUS_FULL;
                                state_reg      <= ST_DONE;
                            end
                            else
                            begin
                                state_reg <= ST_DIV;
                            end
                        end
                        else if (req.operation == OP_READ)
                        begin
                            res_status_reg <= STATUS_READ;
                            res_slot_reg   <= req.slot;
                            state_reg      <= slot_in_range ? ST_READ : ST_DONE;
                        end
                        else if (req.operation == OP_CLEAR)
                        begin
                            filled_reg   <= '0;
                            clr_addr_reg <= '0;
                            state_reg    <= ST_CLEAR;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                    begin
                        res_status_reg <= STATUS_CLEARED;
                        state_reg      <= ST_DONE;
                    end
                end

                ST_DIV:
                begin
                    if (div_a_done)
                    begin
                        issue_pos_reg <= home_rem[ADDR_W-1:0];
                        step_reg      <= ADDR_W'(step_rem + SIZE_W'(1));
                        issue_cnt_reg <= '0;
                        chk_vld_reg   <= 1'b0;
                        state_reg     <= ST_PROBE;
                    end
                end

                ST_PROBE:
                begin
                    priority if (found)
                    begin
                        filled_reg     <= filled_reg + SIZE_W'(1);
                        res_status_reg <= STATUS_INSERTED;
                        res_slot_reg   <= SLOT_W'(chk_pos_reg);
                        res_probe_reg  <= chk_cnt_reg;
                        chk_vld_reg    <= 1'b0;
                        state_reg      <= ST_DONE;
                    end
                    else if (walk_fail)
                    begin
                        res_status_reg <= STATUS_FULL;
                        res_probe_reg  <= eff_size;
                        chk_vld_reg    <= 1'b0;
                        state_reg      <= ST_DONE;
                    end
                    else if (issue)
                    begin
                        chk_pos_reg   <= issue_pos_reg;
                        chk_cnt_reg   <= issue_cnt_reg;
                        chk_vld_reg   <= 1'b1;
                        issue_pos_reg <= next_pos;
                        issue_cnt_reg <= issue_cnt_reg + SIZE_W'(1);
                    end
                    else
                    begin
                        chk_vld_reg <= 1'b0;
                    end
                end

                ST_READ:
                begin
                    res_used_reg <= rd_valid;
                    res_key_reg  <= rd_valid ? mem_rdata[KEY_BITS-1:0] : '0;
                    state_reg    <= ST_DONE;
                end

                ST_DONE:
                begin
                    // hand over once the output register is free
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_slot_reg   <= res_slot_reg;
                        out_key_reg    <= KEY_FIELD_W'(res_key_reg);
                        out_used_reg   <= res_used_reg;
                        out_probe_reg  <= PROBE_W'(res_probe_reg);
                        state_reg      <= ST_IDLE;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // response outputs
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.slot_index  = out_slot_reg;
    assign rsp.key_out     = out_key_reg;
    assign rsp.slot_used   = out_used_reg;
    assign rsp.probe_count = out_probe_reg;

    // checks
    `DHTI_NEVER(a_fill_bound, (32'(filled_reg) > DEPTH), "fill count above depth")
    `DHTI_ASSERT(a_write_empty, ((state_reg == ST_PROBE) && mem_we) |-> (chk_vld_reg && !rd_valid), "probe write to a used slot")
    `DHTI_ASSERT(a_chk_range, ((state_reg == ST_PROBE) && chk_vld_reg) |-> (chk_cnt_reg < eff_size), "probe count beyond size")
    `DHTI_ASSERT(a_div_pair, div_a_done |-> (div_b_done && (state_reg == ST_DIV)), "remainder units out of step")

endmodule

/* tb/tb_double_hash_table_insert_top.sv */
module tb_double_hash_table_insert_top;
    import dhti_pkg::*;

    // operation code that the block drops without a reply
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int QUIET_WAIT     = KEY_FIELD_W + 4 + DHTI_DEPTH + 64;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [SLOT_W-1:0]      slot_index;
        logic [KEY_FIELD_W-1:0] key_out;
        logic                   slot_used;
        logic [PROBE_W-1:0]     probe_count;
    } table_reply_t;

    logic clk = 1'b0;
    logic rst_n;

    dhti_req_if req_if ();
    dhti_rsp_if rsp_if ();
    dhti_cfg_if cfg_if ();

    double_hash_table_insert_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // predicted table contents
    logic [KEY_FIELD_W-1:0] table_keys [DHTI_DEPTH];
    bit                     table_used [DHTI_DEPTH];
    bit                     slot_written [DHTI_DEPTH];
    int unsigned            written_slots [$];
    int unsigned            table_fill = 0;
    logic [TSIZE_W-1:0]     table_size_reg = TSIZE_RESET;

    table_reply_t expected_replies [$];
    table_reply_t head_reply;

    int fail_count    = 0;
    int src_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int rsp_hold_left = 0;
    int quiet_cycles  = 0;

    always #5 clk = ~clk;

    // table size held to the range the store supports
    function automatic int unsigned effective_size();
        int unsigned s;
        s = table_size_reg;
        if (s < MIN_SIZE)
            s = MIN_SIZE;
        if (s > DHTI_DEPTH)
            s = DHTI_DEPTH;
        return s;
    endfunction

    // apply one request to the predicted table, return 1 when a reply follows
    function automatic bit predict_table_op(input logic [OP_W-1:0] op,
                                            input logic [KEY_FIELD_W-1:0] key,
                                            input logic [SLOT_W-1:0] slot,
                                            output table_reply_t reply);
        int unsigned s;
        int unsigned pos;
        int unsigned step;
        reply = '0;
        case (op)
            OP_INSERT:
            begin
                s = effective_size();
                reply.status = STATUS_FULL;
                if (table_fill >= s)
                    return 1'b1;
                pos  = key % s;
                step = 1 + key % (s - 1);
                for (int unsigned i = 0; i < s; i++)
                begin
                    if (!table_used[pos])
                    begin
                        table_keys[pos] = key;
                        table_used[pos] = 1'b1;
                        table_fill++;
                        if (!slot_written[pos])
                        begin
                            slot_written[pos] = 1'b1;
                            written_slots.push_back(pos);
                        end
                        reply.status      = STATUS_INSERTED;
                        reply.slot_index  = SLOT_W'(pos);
                        reply.probe_count = PROBE_W'(i);
                        return 1'b1;
                    end
                    pos += step;
                    if (pos >= s)
                        pos -= s;
                end
                // walk came back without an empty slot
                reply.probe_count = PROBE_W'(s);
                return 1'b1;
            end
            OP_READ:
            begin
                reply.status     = STATUS_READ;
                reply.slot_index = slot;
                if (table_used[slot])
                begin
                    reply.key_out   = table_keys[slot];
                    reply.slot_used = 1'b1;
                end
                return 1'b1;
            end
            OP_CLEAR:
            begin
                foreach (table_used[i])
                    table_used[i] = 1'b0;
                table_fill   = 0;
                reply.status = STATUS_CLEARED;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // send one request transaction, with random idle cycles ahead of it
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [KEY_FIELD_W-1:0] key,
                                input logic [SLOT_W-1:0] slot);
        table_reply_t reply;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.key       <= key;
        req_if.slot      <= slot;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        if (predict_table_op(op, key, slot, reply))
            expected_replies.push_back(reply);
    endtask

    // stop offering and wait until every predicted reply has come back
    task automatic wait_for_replies();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
    endtask

    // size register write, only while the block is idle
    task automatic write_table_size(input logic [TSIZE_W-1:0] value);
        wait_for_replies();
        repeat (QUIET_WAIT) @(posedge clk);
        @(negedge clk);
        cfg_if.valid      <= 1'b1;
        cfg_if.table_size <= value;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        table_size_reg = value;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // mostly inserts, reads of slots that hold or held a key, a few clears
    task automatic send_random_item();
        int unsigned            s;
        int                     pick;
        logic [KEY_FIELD_W-1:0] key;
        logic [SLOT_W-1:0]      slot;
        s    = effective_size();
        pick = $urandom_range(99);
        key  = KEY_FIELD_W'($urandom());
        slot = SLOT_W'($urandom());
        if (pick < 5)
            send_request(OP_CLEAR, key, slot);
        else if (pick < 35 && written_slots.size() != 0)
        begin
            slot = SLOT_W'(written_slots[$urandom_range(written_slots.size() - 1)]);
            send_request(OP_READ, key, slot);
        end
        else
        begin
            // narrow keys collide often and force longer walks
            if (pick >= 75)
                key = KEY_FIELD_W'($urandom_range(4 * s));
            send_request(OP_INSERT, key, slot);
        end
    endtask

    task automatic run_random_phase(input int count, input int src_pct, input int rcv_pct,
                                    input logic [TSIZE_W-1:0] size);
        write_table_size(size);
        src_idle_pct  = src_pct;
        rcv_stall_pct = rcv_pct;
        repeat (count)
        begin
            if ($urandom_range(49) == 0)
                send_request(OP_NONE, KEY_FIELD_W'($urandom()), SLOT_W'($urandom()));
            send_random_item();
        end
    endtask

    // inserts with collisions and duplicates, reads, clear, dropped operation
    task automatic test_insert_read();
        src_idle_pct  = 0;
        rcv_stall_pct = 0;
        send_request(OP_INSERT, 31'd0, '0);
        send_request(OP_INSERT, 31'h7FFF_FFFF, 10'h3FF);
        send_request(OP_INSERT, 31'd1021, '0);
        send_request(OP_INSERT, 31'd0, '0);
        send_request(OP_READ, 31'h7FFF_FFFF, 10'd0);
        send_request(OP_READ, '0, SLOT_W'(written_slots[1]));
        send_request(OP_NONE, 31'h7FFF_FFFF, 10'h3FF);
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_READ, '0, 10'd0);
    endtask

    // size saturation, full table, fruitless walk, size lowered with keys above it
    task automatic test_size_limits();
        write_table_size(11'd0);
        send_request(OP_INSERT, 31'd5, '0);
        send_request(OP_INSERT, 31'd6, '0);
        send_request(OP_INSERT, 31'd7, '0);
        send_request(OP_READ, '0, 10'd1);
        send_request(OP_CLEAR, '0, '0);
        // size 4: key 4 steps by 2 and only sees two occupied slots
        write_table_size(11'd4);
        send_request(OP_INSERT, 31'd0, '0);
        send_request(OP_INSERT, 31'd2, '0);
        send_request(OP_INSERT, 31'd4, '0);
        write_table_size(11'h7FF);
        send_request(OP_INSERT, 31'd1023, '0);
        send_request(OP_INSERT, 31'd2047, '0);
        write_table_size(11'd7);
        send_request(OP_INSERT, 31'd3, '0);
        send_request(OP_INSERT, 31'd10, '0);
        send_request(OP_INSERT, 31'd4, '0);
        send_request(OP_INSERT, 31'd5, '0);
        send_request(OP_READ, '0, 10'd1023);
    endtask

    task automatic test_random_phases();
        int unsigned prime_sizes [8] = '{2, 3, 7, 31, 61, 127, 251, 509};
        run_random_phase(100, 0, 0, 11'd1021);
        run_random_phase(100, 52, 0, 11'd13);
        run_random_phase(100, 0, 52, 11'd1024);
        run_random_phase(100, 26, 26, 11'd6);
        run_random_phase(100, 0, 0, TSIZE_W'(prime_sizes[$urandom_range(7)]));
    endtask

    // receiver holds off while reads keep coming, then the sender waits it out
    task automatic test_backpressure();
        src_idle_pct  = 0;
        rcv_stall_pct = 0;
        @(posedge clk);
        rsp_hold_left = HOLD_CYCLES;
        repeat (20)
            send_request(OP_READ, KEY_FIELD_W'($urandom()),
                         SLOT_W'(written_slots[$urandom_range(written_slots.size() - 1)]));
        wait_for_replies();
        repeat (5)
            send_random_item();
    endtask

    // response ready, with random stalls and long hold-offs
    always @(negedge clk)
    begin
        if (rsp_hold_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            rsp_hold_left--;
        end
        else
            rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    task automatic compare_field(input string name, input logic [31:0] expected,
                                 input logic [31:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected %0h, got %0h", name, expected, actual);
            fail_count++;
        end
    endtask

    // check each reply transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("reply with status %0d while none was expected", rsp_if.status);
                fail_count++;
            end
            else
            begin
                head_reply = expected_replies.pop_front();
                compare_field("status", 32'(head_reply.status), 32'(rsp_if.status));
                compare_field("slot_index", 32'(head_reply.slot_index),
                              32'(rsp_if.slot_index));
                compare_field("key_out", 32'(head_reply.key_out), 32'(rsp_if.key_out));
                compare_field("slot_used", 32'(head_reply.slot_used), 32'(rsp_if.slot_used));
                compare_field("probe_count", 32'(head_reply.probe_count),
                              32'(rsp_if.probe_count));
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("double_hash_table_insert_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.operation  = OP_INSERT;
        req_if.key        = '0;
        req_if.slot       = '0;
        rsp_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.table_size = TSIZE_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_insert_read();
        test_size_limits();
        test_random_phases();
        test_backpressure();

        wait_for_replies();
        repeat (QUIET_WAIT) @(posedge clk);
        if (fail_count == 0 && expected_replies.size() == 0)
            $display("double_hash_table_insert_top: match");
        else
            $display("double_hash_table_insert_top: mismatch");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/dhti_pkg.sv
hdl/dhti_if.sv
hdl/dhti_mod.sv
hdl/dhti_mem.sv
hdl/double_hash_table_insert_top.sv
tb/tb_double_hash_table_insert_top.sv
